@@ rtl/hpam_pkg.sv @@
package hpam_pkg;

    localparam int SHORT_WINDOW_DEF = 30;
    localparam int LONG_WINDOW_DEF  = 600;
    localparam int MOVE_MIN_DEF     = 3;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int LIMIT_W    = 15;
    localparam int USE_W      = 16;
    localparam int COUNT_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_NOD_LIMIT      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_POSTURE_PITCH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_POSTURE_YAW    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_ROLL      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_YAW       = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_USE       = CFG_IDX_W'(7);

    localparam logic [2:0] ACT_CENTRED  = 3'd0;
    localparam logic [2:0] ACT_LEFT     = 3'd1;
    localparam logic [2:0] ACT_RIGHT    = 3'd2;
    localparam logic [2:0] ACT_NOD      = 3'd3;
    localparam logic [2:0] ACT_NO_TRACK = 3'd4;

    localparam logic [1:0] MSG_NONE     = 2'd0;
    localparam logic [1:0] MSG_NO_MOVE  = 2'd1;
    localparam logic [1:0] MSG_LONG_USE = 2'd2;

    typedef struct packed {
        logic               enabled;
        logic [LIMIT_W-1:0] turn_limit;
        logic [LIMIT_W-1:0] nod_limit;
        logic [LIMIT_W-1:0] posture_pitch_limit;
        logic [LIMIT_W-1:0] posture_yaw_limit;
        logic [LIMIT_W-1:0] move_roll_limit;
        logic [LIMIT_W-1:0] move_yaw_limit;
        logic [USE_W-1:0]   long_use_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enabled:             1'b0,
        turn_limit:          LIMIT_W'(1072),
        nod_limit:           LIMIT_W'(1786),
        posture_pitch_limit: LIMIT_W'(2144),
        posture_yaw_limit:   LIMIT_W'(715),
        move_roll_limit:     LIMIT_W'(1072),
        move_yaw_limit:      LIMIT_W'(1072),
        long_use_limit:      USE_W'(7200)
    };

    typedef struct packed {
        logic step;
        logic clear;
    } win_op_t;

endpackage

@@ rtl/hpam_if.sv @@
interface hpam_in_if
    import hpam_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;

    modport source (output valid, output pitch_angle, output roll_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle,
                    input yaw_angle, output ready);
endinterface

interface hpam_out_if
    import hpam_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       tracking;
    logic [2:0] action_code;
    logic       posture_bad;
    logic [1:0] message_code;

    modport source (output valid, output accepted, output tracking,
                    output action_code, output posture_bad, output message_code,
                    input ready);
    modport sink   (input valid, input accepted, input tracking,
                    input action_code, input posture_bad, input message_code,
                    output ready);
endinterface

@@ rtl/hpam_cfg_regs.sv @@
module hpam_cfg_regs
    import hpam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:       cfg_next.enabled             = cfg_wdata[0];
                REG_TURN_LIMIT:    cfg_next.turn_limit          = cfg_wdata[LIMIT_W-1:0];
                REG_NOD_LIMIT:     cfg_next.nod_limit           = cfg_wdata[LIMIT_W-1:0];
                REG_POSTURE_PITCH: cfg_next.posture_pitch_limit = cfg_wdata[LIMIT_W-1:0];
                REG_POSTURE_YAW:   cfg_next.posture_yaw_limit   = cfg_wdata[LIMIT_W-1:0];
                REG_MOVE_ROLL:     cfg_next.move_roll_limit     = cfg_wdata[LIMIT_W-1:0];
                REG_MOVE_YAW:      cfg_next.move_yaw_limit      = cfg_wdata[LIMIT_W-1:0];
                REG_LONG_USE:      cfg_next.long_use_limit      = cfg_wdata[USE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/hpam_short_win.sv @@
module hpam_short_win
    import hpam_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  win_op_t             op,
    input  logic [ANGLE_BITS-2:0] pitch_abs,
    input  logic [ANGLE_BITS-2:0] yaw_abs,
    output logic [ANGLE_BITS-2+$clog2(SHORT_WINDOW+1):0] pitch_sum_next,
    output logic [ANGLE_BITS-2+$clog2(SHORT_WINDOW+1):0] yaw_sum_next
);

    localparam int ABS_W = ANGLE_BITS - 1;
    localparam int SUM_W = ABS_W + $clog2(SHORT_WINDOW + 1);
    localparam int SP_W  = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(SHORT_WINDOW - 1);

    logic [ABS_W-1:0] pitch_store_reg [SHORT_WINDOW];
    logic [ABS_W-1:0] yaw_store_reg   [SHORT_WINDOW];
    logic [SUM_W-1:0] pitch_sum_reg;
    logic [SUM_W-1:0] yaw_sum_reg;
    logic [SP_W-1:0]  pos_reg;
    logic [SP_W-1:0]  pos_next;

    assign pitch_sum_next = pitch_sum_reg - SUM_W'(pitch_store_reg[pos_reg])
                          + SUM_W'(pitch_abs);
    assign yaw_sum_next   = yaw_sum_reg - SUM_W'(yaw_store_reg[pos_reg])
                          + SUM_W'(yaw_abs);

    always_comb
    begin
        pos_next = pos_reg;
        if (op.clear)
        begin
            pos_next = '0;
        end
        else if (op.step)
        begin
            pos_next = (pos_reg == SP_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_sum_reg <= '0;
            yaw_sum_reg   <= '0;
            pos_reg       <= '0;
            for (int i = 0; i < SHORT_WINDOW; i++)
            begin
                pitch_store_reg[i] <= '0;
                yaw_store_reg[i]   <= '0;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            if (op.clear)
            begin
                pitch_sum_reg <= '0;
                yaw_sum_reg   <= '0;
                for (int i = 0; i < SHORT_WINDOW; i++)
                begin
                    pitch_store_reg[i] <= '0;
                    yaw_store_reg[i]   <= '0;
                end
            end
            else if (op.step)
            begin
                pitch_sum_reg            <= pitch_sum_next;
                yaw_sum_reg              <= yaw_sum_next;
                pitch_store_reg[pos_reg] <= pitch_abs;
                yaw_store_reg[pos_reg]   <= yaw_abs;
            end
        end
    end

endmodule

@@ rtl/hpam_long_win.sv @@
module hpam_long_win
    import hpam_pkg::*;
#(
    parameter int LONG_WINDOW = LONG_WINDOW_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  win_op_t                            op,
    input  logic                               moved,
    output logic [$clog2(LONG_WINDOW+1)-1:0]   total_next
);

    localparam int TOT_W = $clog2(LONG_WINDOW + 1);
    localparam int LP_W  = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam logic [LP_W-1:0] LP_LAST = LP_W'(LONG_WINDOW - 1);

    logic             flag_mem [LONG_WINDOW];
    logic             rd_data_reg;
    logic [LP_W-1:0]  pos_reg;
    logic [LP_W-1:0]  pos_next;
    logic             wrapped_reg;
    logic             wrapped_next;
    logic [TOT_W-1:0] total_reg;
    logic             old_flag;

    // entries count only once the ring has gone all the way round since the last clear
    assign old_flag   = wrapped_reg & rd_data_reg;
    assign total_next = total_reg - TOT_W'(old_flag) + TOT_W'(moved);

    always_comb
    begin
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        if (op.clear)
        begin
            pos_next     = '0;
            wrapped_next = 1'b0;
        end
        else if (op.step)
        begin
            pos_next = (pos_reg == LP_LAST) ? '0 : pos_reg + 1'b1;
            if (pos_reg == LP_LAST)
            begin
                wrapped_next = 1'b1;
            end
        end
    end

    // flag at the next ring position is prefetched into rd_data_reg
    always_ff @(posedge clk)
    begin
        if (op.step)
        begin
            flag_mem[pos_reg] <= moved;
        end
        if (op.step && (pos_next == pos_reg))
        begin
            rd_data_reg <= moved;
        end
        else
        begin
            rd_data_reg <= flag_mem[pos_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            total_reg   <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            if (op.clear)
            begin
                total_reg <= '0;
            end
            else if (op.step)
            begin
                total_reg <= total_next;
            end
        end
    end

endmodule

@@ rtl/head_pose_activity_monitor.sv @@
// Channel  | Dir | Beat payload
// ---------+-----+---------------------------------------------------------
// sample   | in  | pitch_angle, roll_angle, yaw_angle (signed, ANGLE_BITS)
// result   | out | accepted, tracking, action_code, posture_bad, message_code
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One beat per cycle sustained while result.ready is high.
// Input register -> window update and classify -> result register.
// Reset clears control state but the fill count; the long window memory is masked by a wrap
// flag, so there is no clearing pass after reset or tracking loss.
// sample.ready drops only when both the input and result registers are full
// and result.ready is low.
module head_pose_activity_monitor
    import hpam_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
    parameter int MOVE_MIN     = MOVE_MIN_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    hpam_in_if.sink               sample,
    hpam_out_if.source            result
);

    localparam int ABS_W   = ANGLE_BITS - 1;
    localparam int SUM_W   = ABS_W + $clog2(SHORT_WINDOW + 1);
    localparam int PROD_W  = LIMIT_W + $clog2(SHORT_WINDOW + 1);
    localparam int PCMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int MCMP_W  = (ABS_W > LIMIT_W) ? ABS_W : LIMIT_W;
    localparam int XW      = ((ANGLE_BITS > LIMIT_W) ? ANGLE_BITS : LIMIT_W) + 1;
    localparam int TOT_W   = $clog2(LONG_WINDOW + 1);
    localparam int MM_W    = (TOT_W > 7) ? TOT_W : 7;
    localparam int FILL_W  = $clog2(LONG_WINDOW + 1);
    localparam int PH_W    = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam int FILL_RST = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam logic [PH_W-1:0]   PH_LAST = PH_W'(LONG_WINDOW - 1);
    localparam logic [PH_W-1:0]   PH_M2   = PH_W'((LONG_WINDOW >= 2) ? LONG_WINDOW - 2 : 0);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LONG_WINDOW);

    function automatic logic [ABS_W-1:0] mag_f(input logic [ANGLE_BITS-1:0] v);
        logic [ANGLE_BITS-1:0] n;
        n = v[ANGLE_BITS-1] ? (~v + 1'b1) : v;
        if (n[ANGLE_BITS-1])
        begin
            return '1;
        end
        return n[ABS_W-1:0];
    endfunction

    cfg_t cfg;

    logic                         s1_valid_reg;
    logic signed [ANGLE_BITS-1:0] s1_pitch_reg;
    logic signed [ANGLE_BITS-1:0] s1_roll_reg;
    logic signed [ANGLE_BITS-1:0] s1_yaw_reg;

    logic       out_valid_reg;
    logic       accepted_reg;
    logic       tracking_reg;
    logic [2:0] action_reg;
    logic       posture_bad_reg;
    logic [1:0] message_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [PH_W-1:0]    phase_reg;
    logic [PH_W-1:0]    phase_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    logic    in_fire;
    logic    adv;
    logic    en;
    logic    lost;
    win_op_t op;

    logic [ABS_W-1:0]  pitch_abs;
    logic [ABS_W-1:0]  roll_abs;
    logic [ABS_W-1:0]  yaw_abs;
    logic [SUM_W-1:0]  pitch_sum_next;
    logic [SUM_W-1:0]  yaw_sum_next;
    logic [PROD_W-1:0] pitch_lim_x;
    logic [PROD_W-1:0] yaw_lim_x;
    logic              moved;
    logic [TOT_W-1:0]  total_next;

    logic signed [XW-1:0] yaw_x;
    logic signed [XW-1:0] pitch_x;
    logic signed [XW-1:0] turn_x;
    logic signed [XW-1:0] nod_x;

    logic [2:0] action_calc;
    logic       bad_calc;
    logic [1:0] msg_calc;
    logic [2:0] action_next;
    logic       bad_next;
    logic [1:0] msg_next;

    hpam_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // handshake
    assign adv          = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || adv;
    assign in_fire      = sample.valid && sample.ready;

    assign en       = cfg.enabled;
    assign lost     = (s1_pitch_reg == '0) && (s1_roll_reg == '0) && (s1_yaw_reg == '0);
    assign op.step  = adv && en && !lost;
    assign op.clear = adv && en && lost;

    assign pitch_abs = mag_f(s1_pitch_reg);
    assign roll_abs  = mag_f(s1_roll_reg);
    assign yaw_abs   = mag_f(s1_yaw_reg);

    assign moved = (MCMP_W'(roll_abs) > MCMP_W'(cfg.move_roll_limit))
                || (MCMP_W'(yaw_abs) > MCMP_W'(cfg.move_yaw_limit));

    hpam_short_win #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_short (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .pitch_abs      (pitch_abs),
        .yaw_abs        (yaw_abs),
        .pitch_sum_next (pitch_sum_next),
        .yaw_sum_next   (yaw_sum_next)
    );

    hpam_long_win #(
        .LONG_WINDOW (LONG_WINDOW)
    ) u_long (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .moved      (moved),
        .total_next (total_next)
    );

    // counters
    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        if (op.clear)
        begin
            fill_next = '0;
            if (count_reg >= COUNT_W'(2))
            begin
                count_next = count_reg - COUNT_W'(2);
                if ({1'b0, phase_reg} >= (PH_W + 1)'(2))
                begin
                    phase_next = phase_reg - PH_W'(2);
                end
                else
                begin
                    phase_next = phase_reg + PH_M2;
                end
            end
            else
            begin
                count_next = '0;
                phase_next = '0;
            end
        end
        else if (op.step)
        begin
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
            phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
            fill_next  = (fill_reg >= FILL_FULL) ? fill_reg : fill_reg + 1'b1;
        end
    end

    // classify
    assign yaw_x   = XW'(s1_yaw_reg);
    assign pitch_x = XW'(s1_pitch_reg);
    assign turn_x  = $signed(XW'(cfg.turn_limit));
    assign nod_x   = $signed(XW'(cfg.nod_limit));

    always_comb
    begin
        if (yaw_x > turn_x)
        begin
            action_calc = ACT_LEFT;
        end
        else if (yaw_x < -turn_x)
        begin
            action_calc = ACT_RIGHT;
        end
        else if (pitch_x < -nod_x)
        begin
            action_calc = ACT_NOD;
        end
        else
        begin
            action_calc = ACT_CENTRED;
        end
    end

    assign pitch_lim_x = PROD_W'(cfg.posture_pitch_limit) * PROD_W'(SHORT_WINDOW);
    assign yaw_lim_x   = PROD_W'(cfg.posture_yaw_limit) * PROD_W'(SHORT_WINDOW);
    assign bad_calc    = !((PCMP_W'(pitch_sum_next) < PCMP_W'(pitch_lim_x))
                        && (PCMP_W'(yaw_sum_next) < PCMP_W'(yaw_lim_x)));

    always_comb
    begin
        msg_calc = MSG_NONE;
        if ((phase_next == '0) && (fill_next >= FILL_FULL)
            && (MM_W'(total_next) < MM_W'(MOVE_MIN)))
        begin
            msg_calc = MSG_NO_MOVE;
        end
        if (count_next > COUNT_W'(cfg.long_use_limit))
        begin
            msg_calc = MSG_LONG_USE;
        end
    end

    always_comb
    begin
        action_next = ACT_CENTRED;
        bad_next    = 1'b0;
        msg_next    = MSG_NONE;
        if (en && lost)
        begin
            action_next = ACT_NO_TRACK;
        end
        else if (en)
        begin
            action_next = action_calc;
            bad_next    = bad_calc;
            msg_next    = msg_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= '0;
            fill_reg      <= FILL_W'(FILL_RST);
        end
        else
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pitch_reg <= sample.pitch_angle;
            s1_roll_reg  <= sample.roll_angle;
            s1_yaw_reg   <= sample.yaw_angle;
        end
        if (adv)
        begin
            accepted_reg    <= en;
            tracking_reg    <= en && !lost;
            action_reg      <= action_next;
            posture_bad_reg <= bad_next;
            message_reg     <= msg_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = accepted_reg;
    assign result.tracking     = tracking_reg;
    assign result.action_code  = action_reg;
    assign result.posture_bad  = posture_bad_reg;
    assign result.message_code = message_reg;

`ifndef SYNTHESIS
    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled without a full pipe");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg} < (PH_W + 1)'(LONG_WINDOW))
        else $error("period phase out of range");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill beyond long window");

    a_clear_zeroes_fill: assert property (@(posedge clk) disable iff (!rst_n)
        op.clear |=> (fill_reg == '0))
        else $error("tracking loss did not clear window fill");

    a_lost_beat_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg && !tracking_reg) |->
        ((action_reg == ACT_NO_TRACK) && !posture_bad_reg && (message_reg == MSG_NONE)))
        else $error("tracking-lost beat carries stray fields");
`endif

endmodule
